>>> sv/efs_pkg.sv
// shared constants for the earliest-free-server scheduler
`default_nettype none
package efs_pkg;
    localparam int TIME_W      = 48;
    localparam int DUR_W       = 32;
    localparam int COUNT_W     = 7;
    localparam int MAX_SERVERS = 64;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
endpackage
`default_nettype wire

>>> sv/earliest_free_server_scheduler_core.sv
// top level: earliest-free-server scheduler around a free-time RAM
//
//  channel | signals                               | dir
//  in      | in_valid, in_stall, arrival_time,     | request in
//          | job_duration                          |
//  out     | out_valid, out_stall, finish_time     | request out
//  cfg     | cfg_we, cfg_data (server_count)       | write only
//
// After reset a clearing pass writes zero to every RAM entry, one a cycle,
// with in_stall high. A request then scans the active servers through the RAM
// read port, one entry a cycle, writes the finish time back and then raises
// out_valid; the next request is accepted only after the result is taken
// with out_stall low. in_stall stays high while a request is in flight or a
// result waits.
`default_nettype none
module earliest_free_server_scheduler_core #(
    parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [efs_pkg::COUNT_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [efs_pkg::TIME_W-1:0]  arrival_time,
    input  wire logic [efs_pkg::DUR_W-1:0]   job_duration,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [efs_pkg::TIME_W-1:0]  finish_time
);
    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int RD = 1 << AW;
    localparam int CW = AW + 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_WRITE, S_OUT} state_t;

    state_t                       state_reg;
    logic [efs_pkg::COUNT_W-1:0]  count_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                cnt_act_reg;
    logic [AW-1:0]                best_reg;
    logic [efs_pkg::TIME_W-1:0]   best_val_reg;
    logic                         have_reg;
    logic [AW-1:0]                tag_reg;
    logic                         tag_vld_reg;
    logic [efs_pkg::TIME_W-1:0]   arr_reg;
    logic [efs_pkg::DUR_W-1:0]    dur_reg;
    logic [efs_pkg::TIME_W-1:0]   fin_reg;

    logic                         we;
    logic [AW-1:0]                waddr;
    logic [efs_pkg::TIME_W-1:0]   wdata;
    logic [AW-1:0]                raddr;
    logic [efs_pkg::TIME_W-1:0]   rdata;
    logic [CW-1:0]                act;
    logic [efs_pkg::TIME_W-1:0]   start;
    logic [efs_pkg::TIME_W:0]     sum;

    efs_ram #(.WIDTH(efs_pkg::TIME_W), .DEPTH(RD)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // active server count, clamped to 1..MAX_SERVERS
    always_comb
    begin
        if (count_reg == '0)
            act = CW'(1);
        else if (32'(count_reg) > MAX_SERVERS)
            act = CW'(MAX_SERVERS);
        else
            act = CW'(count_reg);
    end

    // finish time with saturation
    always_comb
    begin
        start = (arr_reg > best_val_reg) ? arr_reg : best_val_reg;
        sum   = {1'b0, start} + {{(efs_pkg::TIME_W-efs_pkg::DUR_W+1){1'b0}}, dur_reg};
    end

    // memory port control
    always_comb
    begin
        we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
        waddr = (state_reg == S_CLEAR) ? idx_reg[AW-1:0] : best_reg;
        wdata = (state_reg == S_CLEAR) ? '0 :
                (sum[efs_pkg::TIME_W] ? efs_pkg::TIME_MAX : sum[efs_pkg::TIME_W-1:0]);
        raddr = idx_reg[AW-1:0];
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign finish_time = fin_reg;

    // sequencer: clear, scan for minimum, write back, present result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            count_reg    <= efs_pkg::COUNT_W'(1);
            idx_reg      <= '0;
            cnt_act_reg  <= '0;
            best_reg     <= '0;
            best_val_reg <= '0;
            have_reg     <= 1'b0;
            tag_reg      <= '0;
            tag_vld_reg  <= 1'b0;
            arr_reg      <= '0;
            dur_reg      <= '0;
            fin_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (32'(idx_reg) == RD - 1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        arr_reg     <= arrival_time;
                        dur_reg     <= job_duration;
                        cnt_act_reg <= act;
                        idx_reg     <= CW'(1);
                        tag_reg     <= '0;
                        tag_vld_reg <= 1'b1;
                        have_reg    <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // rdata holds entry tag_reg, read last cycle
                    if (tag_vld_reg)
                    begin
                        if (!have_reg || (rdata < best_val_reg))
                        begin
                            best_val_reg <= rdata;
                            best_reg     <= tag_reg;
                        end
                        have_reg <= 1'b1;
                    end
                    if (idx_reg < cnt_act_reg)
                    begin
                        tag_reg     <= idx_reg[AW-1:0];
                        tag_vld_reg <= 1'b1;
                        idx_reg     <= idx_reg + CW'(1);
                    end
                    else if (tag_vld_reg)
                    begin
                        tag_vld_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    fin_reg   <= wdata;
                    idx_reg   <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/efs_ram.sv
// generic single-port-write, single-read RAM with registered read
`default_nettype none
module efs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
